// ----- hdl/sida_pkg.sv -----
`timescale 1ns / 1ps

package sida_pkg;

   // Character codes used in the decimal text.
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;

   // Largest digit value and the double-dabble correction constants.
   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [3:0] BCD_LIMIT = 4'd5;
   localparam logic [3:0] BCD_BIAS  = 4'd3;

   // The running character total saturates at this value.
   localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

   // One result item as it sits in the output queue.
   typedef struct packed {
      logic [7:0]  char_code;
      logic        last_char;
      logic [31:0] total_written;
   } rsp_item_type;

endpackage

// ----- hdl/sida_fifo.sv -----
`timescale 1ns / 1ps

module sida_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end else begin
         // Both or neither: the fill count holds.
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // The fill count never runs past the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// ----- hdl/sida_front.sv -----
`timescale 1ns / 1ps

module sida_front
   import sida_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                 q_push,
   output logic [VALUE_WIDTH:0] q_data,
   input  logic                 q_full
);

   logic                   valid_ff, valid_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   take;

   // The stage holds one classified item until the queue has room.
   assign req_full = valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_data   = {neg_ff, mag_ff};

   // Split the value into sign and unsigned magnitude. The most negative
   // value negates to itself, which read unsigned is its magnitude.
   always_comb begin
      valid_in = valid_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      if (take) begin
         valid_in = 1'b1;
         neg_in   = req_value[VALUE_WIDTH-1];
         mag_in   = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
   end

endmodule

// ----- hdl/sida_back.sv -----
`timescale 1ns / 1ps

module sida_back
   import sida_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_empty,
   input  logic [VALUE_WIDTH:0] in_data,
   output logic                 in_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output rsp_item_type         out_item
);

   localparam int STEPS = (VALUE_WIDTH + 3) / 4;
   localparam int PADW  = STEPS * 4;
   localparam int NDIG  = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BCDW  = NDIG * 4;
   localparam int IDXW  = $clog2(NDIG);
   localparam int STEPW = $clog2(STEPS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_SCAN = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PADW-1:0]   shift_ff, shift_in;
   logic [BCDW-1:0]   bcd_ff, bcd_in;
   logic [STEPW-1:0]  step_ff, step_in;
   logic [IDXW-1:0]   idx_ff, idx_in;
   logic              neg_ff, neg_in;
   logic              sign_pend_ff, sign_pend_in;
   logic [31:0]       total_ff, total_in;
   logic [IDXW-1:0]   lead_idx;
   logic [3:0]        digit;

   // Four double-dabble steps: correct each BCD digit, then shift one bit in.
   function automatic logic [BCDW-1:0] dabble4(input logic [BCDW-1:0] bcd,
                                              input logic [3:0] bits);
      logic [BCDW-1:0] acc;
      acc = bcd;
      for (int b = 3; b >= 0; b--) begin
         for (int d = 0; d < NDIG; d++) begin
            if (acc[d*4 +: 4] >= BCD_LIMIT) begin
               acc[d*4 +: 4] = acc[d*4 +: 4] + BCD_BIAS;
            end
         end
         acc = {acc[BCDW-2:0], bits[b]};
      end
      return acc;
   endfunction

   // Highest nonzero digit; zero itself prints as the single digit 0.
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] != '0) begin
            lead_idx = IDXW'(d);
         end
      end
   end

   assign digit    = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign in_pop   = (state_ff == S_IDLE) && !in_empty;
   assign out_push = (state_ff == S_EMIT) && !out_full;
   assign total_in = out_push ? ((total_ff == TOTAL_MAX) ? total_ff : total_ff + 1'b1)
                              : total_ff;

   // The character under the emit pointer.
   always_comb begin
      out_item.char_code     = sign_pend_ff ? CHAR_MINUS : CHAR_ZERO + {4'b0000, digit};
      out_item.last_char     = !sign_pend_ff && (idx_ff == '0);
      out_item.total_written = total_in;
   end

   // Sequencer: load, convert a nibble a cycle, find the lead digit, emit.
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!in_empty) begin
               neg_in   = in_data[VALUE_WIDTH];
               shift_in = PADW'(in_data[VALUE_WIDTH-1:0]);
               bcd_in   = '0;
               step_in  = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            bcd_in   = dabble4(bcd_ff, shift_ff[PADW-1 -: 4]);
            shift_in = {shift_ff[PADW-5:0], 4'b0000};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEPW'(STEPS - 1)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            idx_in       = lead_idx;
            sign_pend_in = neg_ff;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (!out_full) begin
               if (sign_pend_ff) begin
                  sign_pend_in = 1'b0;
               end else if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      bcd_ff       <= bcd_in;
      step_ff      <= step_in;
      idx_ff       <= idx_in;
      neg_ff       <= neg_in;
      sign_pend_ff <= sign_pend_in;
   end

   // The character total only ever grows or holds.
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("character total went down");

   // Every digit leaving the converter is a valid decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && !sign_pend_ff |-> digit <= DIGIT_MAX)
      else $error("BCD digit out of range");

   // Taking an item starts the conversion at its first nibble.
   a_load_conv: assert property (@(posedge clock) disable iff (reset)
      in_pop |=> (state_ff == S_CONV) && (step_ff == '0))
      else $error("conversion did not start after load");

   // The final character of a value returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      out_push && out_item.last_char |=> state_ff == S_IDLE)
      else $error("sequencer kept emitting after the final character");

endmodule

// ----- hdl/signed_int_to_decimal_ascii_top.sv -----
`timescale 1ns / 1ps

// Channel    Ports                                           Moves
// req        req_push, req_full, req_value                   one integer per item
// rsp        rsp_pop, rsp_empty, rsp_char_code,              one character per item
//            rsp_last_char, rsp_total_written
//
// A value is loaded, converted in ceil(VALUE_WIDTH/4) nibble steps (8 at 32 bits),
// scanned for its lead digit and emitted one character per cycle while there is room.
// The back end's single nibble-serial BCD converter finishes a value before the next.
// Reset is synchronous and clears the queues, the sequencer and the character total.
// A full output queue stalls emission; the front stage and the two-entry middle
// queue keep taking values while the back end is busy.

module signed_int_to_decimal_ascii_top
   import sida_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [7:0]             rsp_char_code,
   output logic                   rsp_last_char,
   output logic [31:0]            rsp_total_written
);

   localparam int QDEPTH = 2;

   logic                 mid_push, mid_full, mid_empty, mid_pop;
   logic [VALUE_WIDTH:0] mid_wr_data, mid_rd_data;
   logic                 out_push, out_full;
   rsp_item_type         out_wr_item, out_rd_item;

   // Front end: sign and magnitude of each accepted value.
   sida_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_value(req_value),
      .q_push   (mid_push),
      .q_data   (mid_wr_data),
      .q_full   (mid_full)
   );

   // Queue between the front and back ends.
   sida_fifo #(
      .WIDTH(VALUE_WIDTH + 1),
      .DEPTH(QDEPTH)
   ) u_mid_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (mid_push),
      .wr_data(mid_wr_data),
      .full   (mid_full),
      .rd_en  (mid_pop),
      .rd_data(mid_rd_data),
      .empty  (mid_empty)
   );

   // Back end: binary to BCD conversion and character emission.
   sida_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .in_empty(mid_empty),
      .in_data (mid_rd_data),
      .in_pop  (mid_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_item(out_wr_item)
   );

   // Output queue decouples the emitter from the consumer.
   sida_fifo #(
      .WIDTH($bits(rsp_item_type)),
      .DEPTH(QDEPTH)
   ) u_out_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (out_push),
      .wr_data(out_wr_item),
      .full   (out_full),
      .rd_en  (rsp_pop),
      .rd_data(out_rd_item),
      .empty  (rsp_empty)
   );

   assign rsp_char_code     = out_rd_item.char_code;
   assign rsp_last_char     = out_rd_item.last_char;
   assign rsp_total_written = out_rd_item.total_written;

endmodule

// ----- test/signed_int_to_decimal_ascii_top_tb.sv -----
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top_tb;
   import sida_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RANDOM_ITEMS_PER_PHASE = 97;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_char_code;
   logic        rsp_last_char;
   logic [31:0] rsp_total_written;

   // Characters still owed by the block, oldest first, and the model's own count.
   rsp_item_type pending_chars[$];
   logic [31:0]  chars_written = '0;
   int           fail_count = 0;

   // Idle rates, in percent of cycles, for the sender and the receiver.
   int send_idle_pct = 0;
   int pop_stall_pct = 0;

   // Directed values, each with its decimal text where it is obvious.
   logic [31:0] row_value[$];
   string       row_text[$];

   signed_int_to_decimal_ascii_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_value         (req_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_char_code     (rsp_char_code),
      .rsp_last_char     (rsp_last_char),
      .rsp_total_written (rsp_total_written)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("signed_int_to_decimal_ascii_top test failed");
      $finish;
   end

   // Queue one expected character and advance the saturating total.
   function automatic void queue_char(input logic [7:0] code, input logic last);
      rsp_item_type item;
      if (chars_written != TOTAL_MAX) begin
         chars_written = chars_written + 32'd1;
      end
      item.char_code = code;
      item.last_char = last;
      item.total_written = chars_written;
      pending_chars.push_back(item);
   endfunction

   // Expected text of one value: sign first, then digits from the unsigned magnitude.
   function automatic void predict_decimal(input logic [31:0] value);
      logic [31:0] magnitude;
      logic [3:0]  digit_buf [10];
      int          ndigits;
      magnitude = value[31] ? (~value + 32'd1) : value;
      ndigits = 0;
      do begin
         digit_buf[ndigits] = 4'(magnitude % 32'd10);
         ndigits++;
         magnitude = magnitude / 32'd10;
      end while (magnitude != 0);
      if (value[31]) begin
         queue_char(CHAR_MINUS, 1'b0);
      end
      for (int i = ndigits - 1; i >= 0; i--) begin
         queue_char(CHAR_ZERO + 8'(digit_buf[i]), i == 0);
      end
   endfunction

   // Expected characters taken straight from a typed string.
   function automatic void queue_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         queue_char(text[i], i == text.len() - 1);
      end
   endfunction

   // Random value: most often a chosen digit count, some raw words, extremes and small numbers.
   function automatic logic [31:0] random_value();
      longint lo;
      longint hi;
      longint pick;
      int     ndigits;
      case ($urandom_range(0, 4))
         0: begin
            pick = longint'($urandom);
         end
         1, 2: begin
            ndigits = $urandom_range(1, 10);
            lo = 1;
            for (int i = 1; i < ndigits; i++) begin
               lo = lo * 10;
            end
            hi = (ndigits == 10) ? 64'd2147483647 : lo * 10 - 1;
            if (ndigits == 1) begin
               lo = 0;
            end
            pick = lo + longint'($urandom_range(0, 32'(hi - lo)));
            if ($urandom_range(0, 1) == 1) begin
               pick = -pick;
            end
         end
         3: begin
            if ($urandom_range(0, 1) == 1) begin
               pick = longint'(32'h7FFF_FFFF - $urandom_range(0, 20));
            end else begin
               pick = longint'(32'h8000_0000 + $urandom_range(0, 20));
            end
         end
         default: begin
            pick = longint'($urandom_range(0, 200));
            if ($urandom_range(0, 1) == 1) begin
               pick = -pick;
            end
         end
      endcase
      return pick[31:0];
   endfunction

   // Offer one value at the falling edge and hold it until the block takes it.
   // An empty text means the predictor supplies the expected characters.
   task automatic send_value(input logic [31:0] value, input string text);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (req_full);
      if (text.len() != 0) begin
         queue_text(text);
      end else begin
         predict_decimal(value);
      end
      @(negedge clock);
   endtask

   // Hold the sender off until every owed character has come out.
   task automatic drain_results();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic add_row(input logic [31:0] value, input string text);
      row_value.push_back(value);
      row_text.push_back(text);
   endtask

   // Receiver: stall pop at random, one decision per falling edge.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
   end

   // Compare each character taken with the oldest expectation.
   always @(posedge clock) begin : check_chars
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_chars.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("unexpected character: code %0d last %0b total %0d",
                        rsp_char_code, rsp_last_char, rsp_total_written);
            end
         end else begin
            want = pending_chars.pop_front();
            if (want.char_code !== rsp_char_code || want.last_char !== rsp_last_char ||
                want.total_written !== rsp_total_written) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("character mismatch: expected code %0d last %0b total %0d, got code %0d last %0b total %0d",
                           want.char_code, want.last_char, want.total_written,
                           rsp_char_code, rsp_last_char, rsp_total_written);
               end
            end
         end
      end
   end

   // Main sequence: reset, directed values, three random phases, with drains after the first and the last.
   initial begin
      add_row(32'd0, "0");
      add_row(32'd1, "1");
      add_row(32'hFFFF_FFFF, "-1");
      add_row(32'd9, "9");
      add_row(32'd10, "10");
      add_row(32'hFFFF_FFF7, "-9");
      add_row(32'hFFFF_FFF6, "-10");
      add_row(32'd99, "99");
      add_row(32'd100, "100");
      add_row(32'h7FFF_FFFF, "2147483647");
      add_row(32'h8000_0000, "-2147483648");
      add_row(32'h8000_0001, "-2147483647");
      add_row(32'd999_999_999, "");
      add_row(32'd1_000_000_000, "");
      add_row(-32'sd999_999_999, "");
      add_row(-32'sd1_000_000_000, "");
      add_row(32'd1_234_567_890, "");
      add_row(32'h5555_5555, "");
      add_row(32'hAAAA_AAAA, "");
      add_row(32'd12_345, "");
      add_row(-32'sd67_890, "");

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Slow receiver first, with a mostly busy sender.
      send_idle_pct = 11;
      pop_stall_pct = 77;
      for (int i = 0; i < row_value.size(); i++) begin
         send_value(row_value[i], row_text[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
         send_value(random_value(), "");
      end
      drain_results();

      // Slow sender, eager receiver.
      send_idle_pct = 77;
      pop_stall_pct = 11;
      for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
         send_value(random_value(), "");
      end

      // No idling on either side.
      send_idle_pct = 0;
      pop_stall_pct = 0;
      for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
         send_value(random_value(), "");
      end
      drain_results();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_chars.size() == 0) begin
         $display("signed_int_to_decimal_ascii_top test passed");
      end else begin
         $display("signed_int_to_decimal_ascii_top test failed");
      end
      $finish;
   end

endmodule
